@@ design/qte_pkg.sv @@
// Shared types, widths and constants for the quaternion to Euler angle pipeline.
// No dependencies; every other design file imports this package.
`default_nettype none
package qte_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ANGLE_BITS_DEF    = 16;

  localparam int IN_W  = 16;   // Q1.15 quaternion parts
  localparam int OUT_W = 16;   // angle ports
  localparam int PW    = 32;   // exact Q2.30 products
  localparam int XW    = 36;   // CORDIC vector width, with room for gain and rotation
  localparam int ZW    = 34;   // accumulated angle, pi = 2^31
  localparam int SW    = 32;   // saturated sine argument, signed, holds plus one exactly
  localparam int NW    = 62;   // square root operand and working value

  localparam int SQRT_STEPS   = 31;
  localparam int FRONT_STAGES = 4;
  localparam int TAB_LEN      = 24;

  localparam int LANES      = 3;
  localparam int LANE_YAW   = 0;
  localparam int LANE_PITCH = 1;
  localparam int LANE_ROLL  = 2;

  localparam logic signed [XW-1:0] ONE_Q30 = XW'(64'sd1073741824);
  localparam logic signed [ZW-1:0] HALF_PI = ZW'(64'sd1073741824);

  typedef struct packed {
    logic signed [XW-1:0] yaw_y;
    logic signed [XW-1:0] yaw_x;
    logic signed [XW-1:0] rol_y;
    logic signed [XW-1:0] rol_x;
    logic signed [SW-1:0] s;
    logic                 clip;
  } front_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
  } vec_t;

  typedef struct packed {
    logic clip;
    logic czero;
    logic neg;
  } pflag_t;

  // atan(2^-i) scaled so that pi = 2^31.
  function automatic logic signed [ZW-1:0] atan_entry(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0:  v = ZW'(64'sd536870912);
      1:  v = ZW'(64'sd316933406);
      2:  v = ZW'(64'sd167458907);
      3:  v = ZW'(64'sd85004756);
      4:  v = ZW'(64'sd42667331);
      5:  v = ZW'(64'sd21354465);
      6:  v = ZW'(64'sd10679838);
      7:  v = ZW'(64'sd5340245);
      8:  v = ZW'(64'sd2670163);
      9:  v = ZW'(64'sd1335087);
      10: v = ZW'(64'sd667544);
      11: v = ZW'(64'sd333772);
      12: v = ZW'(64'sd166886);
      13: v = ZW'(64'sd83443);
      14: v = ZW'(64'sd41722);
      15: v = ZW'(64'sd20861);
      16: v = ZW'(64'sd10430);
      17: v = ZW'(64'sd5215);
      18: v = ZW'(64'sd2608);
      19: v = ZW'(64'sd1304);
      20: v = ZW'(64'sd652);
      21: v = ZW'(64'sd326);
      22: v = ZW'(64'sd163);
      23: v = ZW'(64'sd81);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ design/qte_front.sv @@
// Front end: quaternion products, the three atan2 vectors, the saturated sine
// argument and the square root operand 1 - s*s. Four register stages. Uses qte_pkg.
`default_nettype none
module qte_front import qte_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic signed [IN_W-1:0] q_w,
  input  wire logic signed [IN_W-1:0] q_x,
  input  wire logic signed [IN_W-1:0] q_y,
  input  wire logic signed [IN_W-1:0] q_z,
  output logic                      out_valid,
  output front_t                    out_data,
  output logic [NW-1:0]             out_n
);

  logic v1, v2, v3, v4;
  logic signed [PW-1:0] p_ww, p_xx, p_zz, p_wz, p_xy, p_wx, p_yz, p_wy, p_xz;
  front_t d2, d3, d4;
  front_t d2_next;
  logic [SW-1:0] s_mag, s_mag_next;
  logic [NW-1:0] sq, n4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    p_ww <= q_w * q_w;
    p_xx <= q_x * q_x;
    p_zz <= q_z * q_z;
    p_wz <= q_w * q_z;
    p_xy <= q_x * q_y;
    p_wx <= q_w * q_x;
    p_yz <= q_y * q_z;
    p_wy <= q_w * q_y;
    p_xz <= q_x * q_z;
  end

  always_comb begin
    logic signed [XW-1:0] s_full;
    d2_next.yaw_y = (XW'(p_wz) + XW'(p_xy)) <<< 1;
    d2_next.yaw_x = ((XW'(p_ww) + XW'(p_xx)) <<< 1) - ONE_Q30;
    d2_next.rol_y = (XW'(p_wx) + XW'(p_yz)) <<< 1;
    d2_next.rol_x = ((XW'(p_ww) + XW'(p_zz)) <<< 1) - ONE_Q30;
    s_full        = (XW'(p_wy) - XW'(p_xz)) <<< 1;
    d2_next.clip  = 1'b0;
    if (s_full > ONE_Q30) begin
      s_full       = ONE_Q30;
      d2_next.clip = 1'b1;
    end else if (s_full < -ONE_Q30) begin
      s_full       = -ONE_Q30;
      d2_next.clip = 1'b1;
    end
    d2_next.s  = SW'(s_full);
    s_mag_next = s_full[XW-1] ? SW'(-s_full) : SW'(s_full);
  end

  always_ff @(posedge clk) begin
    d2    <= d2_next;
    s_mag <= s_mag_next;
    d3    <= d2;
    sq    <= NW'(s_mag) * NW'(s_mag);
    d4    <= d3;
    n4    <= (NW'(1) << (2 * (SQRT_STEPS - 1))) - sq;
  end

  assign out_valid = v4;
  assign out_data  = d4;
  assign out_n     = n4;

endmodule
`default_nettype wire

@@ design/qte_isqrt.sv @@
// Pipelined integer square root, one result bit per register stage, with a
// side word carried alongside. Uses qte_pkg.
`default_nettype none
module qte_isqrt import qte_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [NW-1:0]     in_n,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_valid,
  output logic [SW-1:0]          out_root,
  output logic [SIDE_W-1:0]      out_side
);

  logic              vld  [SQRT_STEPS+1];
  logic [NW-1:0]     rem  [SQRT_STEPS+1];
  logic [NW-1:0]     res  [SQRT_STEPS+1];
  logic [SIDE_W-1:0] side [SQRT_STEPS+1];

  assign vld[0]  = in_valid;
  assign rem[0]  = in_n;
  assign res[0]  = '0;
  assign side[0] = in_side;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam logic [NW-1:0] BIT = NW'(1) << (2 * (SQRT_STEPS - 1 - k));
    logic [NW-1:0] trial;
    logic [NW-1:0] rem_next, res_next;

    always_comb begin
      trial = res[k] + BIT;
      if (rem[k] >= trial) begin
        rem_next = rem[k] - trial;
        res_next = (res[k] >> 1) + BIT;
      end else begin
        rem_next = rem[k];
        res_next = res[k] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      rem[k+1]  <= rem_next;
      res[k+1]  <= res_next;
      side[k+1] <= side[k];
    end
  end

  assign out_valid = vld[SQRT_STEPS];
  assign out_root  = SW'(res[SQRT_STEPS]);
  assign out_side  = side[SQRT_STEPS];

endmodule
`default_nettype wire

@@ design/qte_cordic.sv @@
// Three-lane CORDIC vectoring pipeline: a quarter-turn pre-rotation stage, then
// one register stage per iteration. Gives the raw angle with pi = 2^31. Uses qte_pkg.
`default_nettype none
module qte_cordic import qte_pkg::*; #(
  parameter int STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  input  wire vec_t [LANES-1:0]           in_vec,
  input  wire pflag_t                     in_flag,
  output logic                            out_valid,
  output logic [LANES-1:0][ZW-1:0]        out_angle,
  output pflag_t                          out_flag
);

  localparam int N = (STAGES < TAB_LEN) ? STAGES : TAB_LEN;

  logic                      vld  [N+1];
  vec_t   [LANES-1:0]        v    [N+1];
  logic   [LANES-1:0][ZW-1:0] z   [N+1];
  logic   [LANES-1:0]        zf   [N+1];
  pflag_t                    fl   [N+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
  end

  // A vector in the left half plane is turned by a quarter turn first.
  for (genvar l = 0; l < LANES; l++) begin : g_pre
    always_ff @(posedge clk) begin
      zf[0][l] <= (in_vec[l].x == '0) && (in_vec[l].y == '0);
      if (in_vec[l].x < 0) begin
        if (in_vec[l].y >= 0) begin
          v[0][l].x <= in_vec[l].y;
          v[0][l].y <= -in_vec[l].x;
          z[0][l]   <= HALF_PI;
        end else begin
          v[0][l].x <= -in_vec[l].y;
          v[0][l].y <= in_vec[l].x;
          z[0][l]   <= -HALF_PI;
        end
      end else begin
        v[0][l] <= in_vec[l];
        z[0][l] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    fl[0] <= in_flag;
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    localparam logic signed [ZW-1:0] ANG = atan_entry(i);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic signed [XW-1:0] dx, dy, y_cur;
      logic signed [ZW-1:0] z_cur;
      assign y_cur = v[i][l].y;
      assign z_cur = z[i][l];
      assign dx    = y_cur >>> i;
      assign dy    = v[i][l].x >>> i;

      always_ff @(posedge clk) begin
        if (y_cur >= 0) begin
          v[i+1][l].x <= v[i][l].x + dx;
          v[i+1][l].y <= y_cur - dy;
          z[i+1][l]   <= z_cur + ANG;
        end else begin
          v[i+1][l].x <= v[i][l].x - dx;
          v[i+1][l].y <= y_cur + dy;
          z[i+1][l]   <= z_cur - ANG;
        end
      end
    end

    always_ff @(posedge clk) begin
      zf[i+1] <= zf[i];
      fl[i+1] <= fl[i];
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign out_angle[l] = zf[N][l] ? '0 : z[N][l];
  end

  assign out_valid = vld[N];
  assign out_flag  = fl[N];

endmodule
`default_nettype wire

@@ design/quaternion_to_euler_angles.sv @@
// Top level of the quaternion to yaw/pitch/roll converter.
// Depends on qte_pkg, qte_front, qte_isqrt and qte_cordic.
//
// A quaternion word is taken on any cycle with start high; busy is never raised,
// so one word per clock is sustained. Its angles appear with done high after four
// front-end stages, 31 square root stages, one pre-rotation stage, one stage per
// CORDIC iteration and one output stage. The receiver cannot stall the block, so
// each result is present for a single cycle and must be taken then.
`default_nettype none
module quaternion_to_euler_angles import qte_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
  parameter int ANGLE_BITS    = ANGLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic signed [IN_W-1:0] q_w,
  input  wire logic signed [IN_W-1:0] q_x,
  input  wire logic signed [IN_W-1:0] q_y,
  input  wire logic signed [IN_W-1:0] q_z,
  output logic                        done,
  output logic signed [OUT_W-1:0]     yaw_angle,
  output logic signed [OUT_W-1:0]     pitch_angle,
  output logic signed [OUT_W-1:0]     roll_angle,
  output logic                        asin_clipped
);

  localparam int SH = 32 - ANGLE_BITS;
  localparam logic signed [ZW-1:0] HALF_LSB = ZW'(1) <<< (SH - 1);
  localparam logic signed [ZW-1:0] QUARTER  = ZW'(1) <<< (ANGLE_BITS - 2);

  logic               f_valid;
  front_t             f_data;
  logic [NW-1:0]      f_n;
  logic               r_valid;
  logic [SW-1:0]      r_root;
  front_t             r_data;
  vec_t [LANES-1:0]   c_vec;
  pflag_t             c_flag;
  logic               a_valid;
  logic [LANES-1:0][ZW-1:0] a_angle;
  pflag_t             a_flag;
  logic signed [ZW-1:0] yaw_r, pitch_r, roll_r, pitch_c;

  assign busy = 1'b0;

  qte_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start),
    .q_w       (q_w),
    .q_x       (q_x),
    .q_y       (q_y),
    .q_z       (q_z),
    .out_valid (f_valid),
    .out_data  (f_data),
    .out_n     (f_n)
  );

  qte_isqrt #(
    .SIDE_W ($bits(front_t))
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_n      (f_n),
    .in_side   (f_data),
    .out_valid (r_valid),
    .out_root  (r_root),
    .out_side  (r_data)
  );

  // Pitch is atan2(s, sqrt(1 - s*s)).
  always_comb begin
    c_vec[LANE_YAW].x   = r_data.yaw_x;
    c_vec[LANE_YAW].y   = r_data.yaw_y;
    c_vec[LANE_PITCH].x = XW'(signed'({1'b0, r_root}));
    c_vec[LANE_PITCH].y = XW'(r_data.s);
    c_vec[LANE_ROLL].x  = r_data.rol_x;
    c_vec[LANE_ROLL].y  = r_data.rol_y;
    c_flag.clip         = r_data.clip;
    c_flag.czero        = (r_root == '0);
    c_flag.neg          = r_data.s[SW-1];
  end

  qte_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (r_valid),
    .in_vec    (c_vec),
    .in_flag   (c_flag),
    .out_valid (a_valid),
    .out_angle (a_angle),
    .out_flag  (a_flag)
  );

  always_comb begin
    yaw_r   = (signed'(a_angle[LANE_YAW])   + HALF_LSB) >>> SH;
    pitch_r = (signed'(a_angle[LANE_PITCH]) + HALF_LSB) >>> SH;
    roll_r  = (signed'(a_angle[LANE_ROLL])  + HALF_LSB) >>> SH;
    // A vanishing cosine means the sine sits at unit magnitude.
    if (a_flag.czero) begin
      pitch_c = a_flag.neg ? -QUARTER : QUARTER;
    end else if (pitch_r > QUARTER) begin
      pitch_c = QUARTER;
    end else if (pitch_r < -QUARTER) begin
      pitch_c = -QUARTER;
    end else begin
      pitch_c = pitch_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    yaw_angle    <= OUT_W'(yaw_r[ANGLE_BITS-1:0]);
    pitch_angle  <= OUT_W'(pitch_c[ANGLE_BITS-1:0]);
    roll_angle   <= OUT_W'(roll_r[ANGLE_BITS-1:0]);
    asin_clipped <= a_flag.clip;
  end

endmodule
`default_nettype wire

@@ design/qte_checker.sv @@
// Port-level checks on the quaternion to Euler angle converter, bound to its
// top level. Uses qte_pkg for the pipeline depth.
`default_nettype none
module qte_checker import qte_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
  parameter int ANGLE_BITS    = ANGLE_BITS_DEF
) (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   start,
  input wire logic                   busy,
  input wire logic signed [IN_W-1:0] q_w,
  input wire logic signed [IN_W-1:0] q_x,
  input wire logic signed [IN_W-1:0] q_y,
  input wire logic signed [IN_W-1:0] q_z,
  input wire logic                   done,
  input wire logic signed [OUT_W-1:0] yaw_angle,
  input wire logic signed [OUT_W-1:0] pitch_angle,
  input wire logic signed [OUT_W-1:0] roll_angle,
  input wire logic                   asin_clipped
);

  localparam int N   = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;
  localparam int LAT = FRONT_STAGES + SQRT_STEPS + N + 2;
  localparam logic [ANGLE_BITS-1:0] QP = {2'b01, {(ANGLE_BITS-2){1'b0}}};
  localparam logic [ANGLE_BITS-1:0] QN = {2'b11, {(ANGLE_BITS-2){1'b0}}};

  a_no_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");

  a_reset_clears: assert property (@(posedge clk) rst |=> !done)
    else $error("result word straight after reset");

  a_word_in_out: assert property (@(posedge clk) disable iff (rst)
    start |-> ##LAT done)
    else $error("accepted word produced no result");

  a_no_ghost: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result word without an accepted word");

  // A saturated sine argument always lands on exactly a quarter turn.
  a_clip_pitch: assert property (@(posedge clk) disable iff (rst)
    (done && asin_clipped) |->
      (pitch_angle == OUT_W'(QP) || pitch_angle == OUT_W'(QN)))
    else $error("clipped pitch not at a quarter turn");

endmodule

bind quaternion_to_euler_angles qte_checker #(
  .CORDIC_STAGES (CORDIC_STAGES),
  .ANGLE_BITS    (ANGLE_BITS)
) u_qte_checker (.*);
`default_nettype wire
